// ===== sv/timer_bank_with_wrapping_tick_counter_core_macros.svh =====
// Assertion macros used by the timer bank checker
`ifndef TIMER_BANK_WITH_WRAPPING_TICK_COUNTER_CORE_MACROS_SVH
`define TIMER_BANK_WITH_WRAPPING_TICK_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define TBW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank assertion failed");

// next-cycle implication
`define TBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank assertion failed");

`endif

// ===== sv/tbw_pkg.sv =====
// Types and codes of the timer bank
package tbw_pkg;

   localparam int KIND_W     = 2;
   localparam int ID_W       = 4;
   localparam int DUR_W      = 32;
   localparam int STATE_W    = 2;
   localparam int TICK_OUT_W = 32;
   localparam int LIMIT_W    = 32;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK = 2'd3;

   localparam logic [STATE_W-1:0] TMR_CLEARED = 2'd0;
   localparam logic [STATE_W-1:0] TMR_STARTED = 2'd1;
   localparam logic [STATE_W-1:0] TMR_ENDED   = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EXEC = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic load_sum;
      logic commit;
   } dp_cmd_type;

endpackage

// ===== sv/tbw_if.sv =====
// Channel interfaces of the timer bank: request, response, configuration
interface tbw_req_if;
   logic                       valid;
   logic                       ready;
   logic [tbw_pkg::KIND_W-1:0] kind;
   logic [tbw_pkg::ID_W-1:0]   timer_id;
   logic [tbw_pkg::DUR_W-1:0]  duration;

   modport source (output valid, output kind, output timer_id, output duration, input ready);
   modport sink (input valid, input kind, input timer_id, input duration, output ready);
endinterface

interface tbw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tbw_pkg::STATE_W-1:0]    timer_state;
   logic [tbw_pkg::TICK_OUT_W-1:0] tick_count;

   modport source (output valid, output timer_state, output tick_count, input ready);
   modport sink (input valid, input timer_state, input tick_count, output ready);
endinterface

interface tbw_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tbw_pkg::LIMIT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tbw_ctrl.sv =====
// Controller: sequences accept, read/sum and update, owns the response valid
module tbw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tbw_pkg::dp_cmd_type cmd
);

   tbw_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tbw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = tbw_pkg::ST_READ;
            end
         end
         tbw_pkg::ST_READ: begin
            cmd.load_sum = 1'b1;
            state_in     = tbw_pkg::ST_EXEC;
         end
         tbw_pkg::ST_EXEC: begin
            // update waits only for the result slot
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = tbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/tbw_datapath.sv =====
// Datapath: tick counter, wrap limit, target memory, status table, result register
module tbw_datapath #(
   parameter int TIMER_COUNT = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tbw_pkg::dp_cmd_type               cmd,
   input  logic [tbw_pkg::KIND_W-1:0]        req_kind,
   input  logic [tbw_pkg::ID_W-1:0]          req_timer_id,
   input  logic [tbw_pkg::DUR_W-1:0]         req_duration,
   input  logic                              csr_valid,
   input  logic [tbw_pkg::LIMIT_W-1:0]       csr_data,
   output logic [tbw_pkg::STATE_W-1:0]       rsp_timer_state,
   output logic [tbw_pkg::TICK_OUT_W-1:0]    rsp_tick_count
);

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int WIDE_W = (COUNT_WIDTH > tbw_pkg::DUR_W) ? COUNT_WIDTH : tbw_pkg::DUR_W;
   localparam int SUM_W = WIDE_W + 1;

   logic [tbw_pkg::KIND_W-1:0]  kind_ff;
   logic [tbw_pkg::ID_W-1:0]    id_ff;
   logic [tbw_pkg::DUR_W-1:0]   dur_ff;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [tbw_pkg::LIMIT_W-1:0] limit_ff;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]      tgt_rd_ff;
   logic [tbw_pkg::STATE_W-1:0] status_ff [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0]      target_mem [TIMER_COUNT];
   logic [tbw_pkg::STATE_W-1:0] state_out_ff, state_out_in;
   logic [tbw_pkg::TICK_OUT_W-1:0] tick_out_ff;

   logic [IDX_W-1:0]            rd_idx, wr_idx;
   logic                        id_ok;
   logic [SUM_W-1:0]            limit_w, diff;
   logic [COUNT_WIDTH-1:0]      reduced;
   logic [tbw_pkg::STATE_W-1:0] cur_st, next_st;

   assign rd_idx = IDX_W'(req_timer_id);
   assign wr_idx = IDX_W'(id_ff);
   assign id_ok  = {28'd0, id_ff} < 32'(TIMER_COUNT);

   // tick adds one, set adds the duration
   assign sum_in = SUM_W'(count_ff) +
                   ((kind_ff == tbw_pkg::KIND_TICK) ? SUM_W'(1) : SUM_W'(dur_ff));

   // limit taken off once when exceeded
   assign limit_w = SUM_W'(limit_ff);
   assign diff    = sum_ff - limit_w;
   assign reduced = (sum_ff > limit_w) ? diff[COUNT_WIDTH-1:0] : sum_ff[COUNT_WIDTH-1:0];

   assign cur_st   = status_ff[wr_idx];
   assign count_in = (kind_ff == tbw_pkg::KIND_TICK) ? reduced : count_ff;

   always_comb begin
      case (kind_ff)
         tbw_pkg::KIND_SET:   next_st = tbw_pkg::TMR_STARTED;
         tbw_pkg::KIND_CLEAR: next_st = tbw_pkg::TMR_CLEARED;
         tbw_pkg::KIND_CHECK: begin
            // plain magnitude compare, no wrap awareness
            if (cur_st == tbw_pkg::TMR_STARTED && tgt_rd_ff <= count_ff) begin
               next_st = tbw_pkg::TMR_ENDED;
            end else begin
               next_st = cur_st;
            end
         end
         default: next_st = cur_st;
      endcase
   end

   assign state_out_in = id_ok ? next_st : tbw_pkg::TMR_CLEARED;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff   <= req_kind;
         id_ff     <= req_timer_id;
         dur_ff    <= req_duration;
         tgt_rd_ff <= target_mem[rd_idx];
      end
      if (cmd.load_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.commit && id_ok && kind_ff == tbw_pkg::KIND_SET) begin
         target_mem[wr_idx] <= reduced;
      end
      if (cmd.commit) begin
         state_out_ff <= state_out_in;
         tick_out_ff  <= tbw_pkg::TICK_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= tbw_pkg::LIMIT_RESET;
         for (int i = 0; i < TIMER_COUNT; i++) begin
            status_ff[i] <= tbw_pkg::TMR_CLEARED;
         end
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.commit) begin
            count_ff <= count_in;
            if (id_ok) begin
               status_ff[wr_idx] <= next_st;
            end
         end
      end
   end

   assign rsp_timer_state = state_out_ff;
   assign rsp_tick_count  = tick_out_ff;

endmodule

// ===== sv/timer_bank_with_wrapping_tick_counter_core.sv =====
// Top level of the timer bank with a shared wrapping tick counter
//
//   channel  | dir | handshake    | word
//   req_ch   | in  | valid/ready  | kind, timer_id, duration
//   rsp_ch   | out | valid/ready  | timer_state, tick_count
//   csr_ch   | in  | valid/ready  | wrap limit (ready always high)
//
// Each item steps through accept with the target RAM read, the count+operand add,
// then reduce by the limit and update. The registered target read and the
// add/reduce register split give these steps.
// Reset is synchronous; the status table clears at once, targets are not cleared.
// A held response stalls only the update step; the next word is not accepted until that update.
module timer_bank_with_wrapping_tick_counter_core #(
   parameter int TIMER_COUNT = 16,
   parameter int COUNT_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   tbw_req_if.sink   req_ch,
   tbw_rsp_if.source rsp_ch,
   tbw_csr_if.sink   csr_ch
);

   tbw_pkg::dp_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   tbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tbw_datapath #(
      .TIMER_COUNT (TIMER_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_ch.kind),
      .req_timer_id    (req_ch.timer_id),
      .req_duration    (req_ch.duration),
      .csr_valid       (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_timer_state (rsp_ch.timer_state),
      .rsp_tick_count  (rsp_ch.tick_count)
   );

endmodule

// ===== sv/tbw_checker.sv =====
// Port-level checks for the timer bank, bound to the top level
`include "timer_bank_with_wrapping_tick_counter_core_macros.svh"

module tbw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [tbw_pkg::STATE_W-1:0]        timer_state,
   input logic [tbw_pkg::TICK_OUT_W-1:0]     tick_count
);

   // one word in flight: no accept right after an accept
   `TBW_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   `TBW_ASSERT_IMPLY(a_state_code, clock, reset, rsp_valid, timer_state <= tbw_pkg::TMR_ENDED)

   `TBW_ASSERT_IMPLY(a_rsp_hold, clock, reset, !$past(reset) && $past(rsp_valid && !rsp_ready), rsp_valid)

   `TBW_ASSERT_IMPLY(a_rsp_stable, clock, reset, !$past(reset) && $past(rsp_valid && !rsp_ready), $stable(timer_state) && $stable(tick_count))

endmodule

bind timer_bank_with_wrapping_tick_counter_core tbw_checker u_tbw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .timer_state (rsp_ch.timer_state),
   .tick_count  (rsp_ch.tick_count)
);

// ===== tb/timer_bank_with_wrapping_tick_counter_core_tb.sv =====
// Self-checking testbench of the timer bank: directed and random traffic against a built-in timer model
module timer_bank_with_wrapping_tick_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TIMERS = 16;
   localparam int SETTLE     = 6;    // quiet cycles before a limit write
   localparam int CALM_LO    = 400;  // no idling while the word count is in this span
   localparam int CALM_HI    = 520;

   typedef enum logic [1:0] {
      ENTRY_OP,
      ENTRY_LIMIT,
      ENTRY_PAUSE
   } entry_kind_type;

   typedef struct {
      entry_kind_type                 what;
      logic [tbw_pkg::KIND_W-1:0]     kind;
      logic [tbw_pkg::ID_W-1:0]       timer_id;
      logic [tbw_pkg::DUR_W-1:0]      operand;
   } op_entry_type;

   typedef struct {
      logic [tbw_pkg::STATE_W-1:0]    timer_state;
      logic [tbw_pkg::TICK_OUT_W-1:0] tick_count;
      logic [tbw_pkg::KIND_W-1:0]     kind;
      logic [tbw_pkg::ID_W-1:0]       timer_id;
   } due_result_type;

   logic clock;
   logic reset;

   tbw_req_if req_bus();
   tbw_rsp_if rsp_bus();
   tbw_csr_if csr_bus();

   timer_bank_with_wrapping_tick_counter_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   op_entry_type   pending_ops[$];
   due_result_type due_results[$];

   // timer model
   logic [tbw_pkg::LIMIT_W-1:0]    limit_model;
   logic [tbw_pkg::TICK_OUT_W-1:0] tick_model;
   logic [tbw_pkg::TICK_OUT_W-1:0] deadline [NUM_TIMERS];
   logic [tbw_pkg::STATE_W-1:0]    timer_phase [NUM_TIMERS];

   // generator bookkeeping: timers that have had a set queued so far
   logic [NUM_TIMERS-1:0] ever_set;

   logic req_took;
   logic csr_took;
   int   quiet_cycles;
   int   words_sent;
   int   results_seen;
   int   errors;
   int   n_sets;
   int   n_checks;
   int   n_ended;
   int   n_limits;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [tbw_pkg::TICK_OUT_W-1:0] fold_by_limit(
      input logic [tbw_pkg::TICK_OUT_W:0] sum);
      if (sum > {1'b0, limit_model})
         sum = sum - {1'b0, limit_model};
      return sum[tbw_pkg::TICK_OUT_W-1:0];
   endfunction

   task automatic step_timers(input logic [tbw_pkg::KIND_W-1:0] kind,
                              input logic [tbw_pkg::ID_W-1:0] id,
                              input logic [tbw_pkg::DUR_W-1:0] dur,
                              output due_result_type res);
      case (kind)
         tbw_pkg::KIND_TICK: begin
            tick_model = fold_by_limit({1'b0, tick_model} + 1'b1);
         end
         tbw_pkg::KIND_SET: begin
            deadline[id]    = fold_by_limit({1'b0, tick_model} + {1'b0, dur});
            timer_phase[id] = tbw_pkg::TMR_STARTED;
         end
         tbw_pkg::KIND_CLEAR: begin
            timer_phase[id] = tbw_pkg::TMR_CLEARED;
         end
         tbw_pkg::KIND_CHECK: begin
            // plain compare, no wrap awareness
            if (timer_phase[id] == tbw_pkg::TMR_STARTED && deadline[id] <= tick_model)
               timer_phase[id] = tbw_pkg::TMR_ENDED;
         end
         default: ;
      endcase
      res.timer_state = timer_phase[id];
      res.tick_count  = tick_model;
      res.kind        = kind;
      res.timer_id    = id;
   endtask

   // ---------------------------------------------------------------- generator
   task automatic add_op(input logic [tbw_pkg::KIND_W-1:0] kind,
                         input logic [tbw_pkg::ID_W-1:0] id,
                         input logic [tbw_pkg::DUR_W-1:0] dur);
      op_entry_type e;
      e.what     = ENTRY_OP;
      e.kind     = kind;
      e.timer_id = id;
      e.operand  = dur;
      pending_ops.push_back(e);
      if (kind == tbw_pkg::KIND_SET) begin
         ever_set[id] = 1'b1;
         n_sets++;
      end
      if (kind == tbw_pkg::KIND_CHECK)
         n_checks++;
   endtask

   task automatic add_limit(input logic [tbw_pkg::LIMIT_W-1:0] value);
      op_entry_type e;
      e.what     = ENTRY_LIMIT;
      e.kind     = tbw_pkg::KIND_TICK;
      e.timer_id = '0;
      e.operand  = value;
      pending_ops.push_back(e);
      n_limits++;
   endtask

   task automatic add_pause();
      op_entry_type e;
      e.what     = ENTRY_PAUSE;
      e.kind     = tbw_pkg::KIND_TICK;
      e.timer_id = '0;
      e.operand  = '0;
      pending_ops.push_back(e);
   endtask

   function automatic logic [tbw_pkg::DUR_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return tbw_pkg::DUR_W'($urandom_range(0, 12));
      else if (r < 70)
         return 32'hFFFF_FFFF - tbw_pkg::DUR_W'($urandom_range(0, 12));
      else
         return tbw_pkg::DUR_W'($urandom);
   endfunction

   // one pick in four starts a set / ticks / check run, the rest loose traffic
   task automatic add_random_ops(input int n);
      int made;
      int pick;
      int span;
      int ticks;
      logic [tbw_pkg::ID_W-1:0] id;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         id   = tbw_pkg::ID_W'($urandom_range(0, NUM_TIMERS - 1));
         if (pick < 25) begin
            span  = $urandom_range(0, 6);
            ticks = span + int'($urandom_range(0, 2)) - 1;
            if (ticks < 0)
               ticks = 0;
            add_op(tbw_pkg::KIND_SET, id, tbw_pkg::DUR_W'(span));
            repeat (ticks)
               add_op(tbw_pkg::KIND_TICK, tbw_pkg::ID_W'($urandom),
                      tbw_pkg::DUR_W'($urandom));
            add_op(tbw_pkg::KIND_CHECK, id, tbw_pkg::DUR_W'($urandom));
            made += ticks + 2;
         end else begin
            if (pick < 50)
               add_op(tbw_pkg::KIND_TICK, id, tbw_pkg::DUR_W'($urandom));
            else if (pick < 68 || !ever_set[id])
               add_op(tbw_pkg::KIND_SET, id, pick_duration());
            else if (pick < 78)
               add_op(tbw_pkg::KIND_CLEAR, id, tbw_pkg::DUR_W'($urandom));
            else
               add_op(tbw_pkg::KIND_CHECK, id, tbw_pkg::DUR_W'($urandom));
            made++;
         end
      end
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin : feed
      op_entry_type head;
      logic         drive_req;
      logic         drive_csr;
      logic         calm;
      if (!reset) begin
         drive_req = req_bus.valid && !req_took;
         drive_csr = csr_bus.valid && !csr_took;
         calm      = words_sent >= CALM_LO && words_sent < CALM_HI;
         if (!drive_req && !drive_csr && pending_ops.size() > 0) begin
            head = pending_ops[0];
            if (head.what == ENTRY_OP) begin
               if (calm || $urandom_range(0, 99) >= 30) begin
                  void'(pending_ops.pop_front());
                  req_bus.kind     <= head.kind;
                  req_bus.timer_id <= head.timer_id;
                  req_bus.duration <= head.operand;
                  drive_req = 1'b1;
               end
            end else if (quiet_cycles >= SETTLE) begin
               // block is drained: safe to touch the limit
               void'(pending_ops.pop_front());
               if (head.what == ENTRY_LIMIT) begin
                  csr_bus.data <= head.operand;
                  drive_csr = 1'b1;
               end
            end
         end
         req_bus.valid <= drive_req;
         csr_bus.valid <= drive_csr;
      end
   end

   always @(negedge clock) begin : drain
      if (!reset)
         rsp_bus.ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                          $urandom_range(0, 99) >= 30;
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : watch
      due_result_type res;
      due_result_type want;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      csr_took <= !reset && csr_bus.valid && csr_bus.ready;
      if (reset) begin
         limit_model = tbw_pkg::LIMIT_RESET;
         tick_model  = '0;
         for (int i = 0; i < NUM_TIMERS; i++)
            timer_phase[i] = tbw_pkg::TMR_CLEARED;
         quiet_cycles <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready)
            limit_model = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            step_timers(req_bus.kind, req_bus.timer_id, req_bus.duration, res);
            if (res.kind == tbw_pkg::KIND_CHECK && res.timer_state == tbw_pkg::TMR_ENDED)
               n_ended++;
            due_results.push_back(res);
            words_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               $error("result word with nothing outstanding: timer_state=%0d tick_count=%0h",
                      rsp_bus.timer_state, rsp_bus.tick_count);
               errors++;
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.timer_state !== want.timer_state) begin
                  $error("timer_state (kind %0d, timer %0d): expected %0d, actual %0d",
                         want.kind, want.timer_id, want.timer_state, rsp_bus.timer_state);
                  errors++;
               end
               if (rsp_bus.tick_count !== want.tick_count) begin
                  $error("tick_count (kind %0d, timer %0d): expected %0h, actual %0h",
                         want.kind, want.timer_id, want.tick_count, rsp_bus.tick_count);
                  errors++;
               end
            end
         end
         if (due_results.size() == 0 && !req_bus.valid && !csr_bus.valid)
            quiet_cycles <= quiet_cycles + 1;
         else
            quiet_cycles <= 0;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin : run
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.kind     = tbw_pkg::KIND_TICK;
      req_bus.timer_id = '0;
      req_bus.duration = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.data     = '0;
      rsp_bus.ready    = 1'b0;
      req_took         = 1'b0;
      csr_took         = 1'b0;
      quiet_cycles     = 0;
      words_sent       = 0;
      results_seen     = 0;
      errors           = 0;
      n_sets           = 0;
      n_checks         = 0;
      n_ended          = 0;
      n_limits         = 0;
      ever_set         = '0;

      // never-set timers read cleared
      add_op(tbw_pkg::KIND_TICK, 4'd0, 32'h0000_0000);
      add_op(tbw_pkg::KIND_CLEAR, 4'd15, 32'hFFFF_FFFF);
      add_op(tbw_pkg::KIND_TICK, 4'd15, 32'hAAAA_AAAA);
      // zero duration ends at once
      add_op(tbw_pkg::KIND_SET, 4'd0, 32'h0000_0000);
      add_op(tbw_pkg::KIND_CHECK, 4'd0, 32'h5555_5555);
      // full duration wraps the target round onto the count
      add_op(tbw_pkg::KIND_SET, 4'd1, 32'hFFFF_FFFF);
      add_op(tbw_pkg::KIND_CHECK, 4'd1, 32'h0000_0000);
      // short timer: started, then ended after its ticks, then cleared
      add_op(tbw_pkg::KIND_SET, 4'd2, 32'd3);
      add_op(tbw_pkg::KIND_CHECK, 4'd2, 32'h0);
      repeat (3) add_op(tbw_pkg::KIND_TICK, 4'd7, 32'hFFFF_FFFF);
      add_op(tbw_pkg::KIND_CHECK, 4'd2, 32'h0);
      add_op(tbw_pkg::KIND_CLEAR, 4'd2, 32'h0);
      add_op(tbw_pkg::KIND_CHECK, 4'd2, 32'h0);
      // tick reports a started timer unchanged
      add_op(tbw_pkg::KIND_SET, 4'd15, 32'h5555_5555);
      add_op(tbw_pkg::KIND_TICK, 4'd15, 32'h0);
      add_op(tbw_pkg::KIND_CHECK, 4'd15, 32'h0);
      add_op(tbw_pkg::KIND_SET, 4'd10, 32'hAAAA_AAAA);
      add_op(tbw_pkg::KIND_SET, 4'd5, 32'h8000_0000);
      add_op(tbw_pkg::KIND_CHECK, 4'd5, 32'h0);

      add_random_ops(130);
      add_limit(32'd6);            // count sits above the new limit
      add_random_ops(130);
      add_limit(32'd1);
      add_random_ops(70);
      add_limit(tbw_pkg::LIMIT_W'($urandom_range(2, 32'hFFFF_FFFE)));
      add_random_ops(80);
      add_pause();
      add_random_ops(80);
      add_limit(32'd9);
      add_random_ops(130);
      add_limit(32'hFFFF_FFFF);
      add_random_ops(110);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_bus.valid || csr_bus.valid ||
             due_results.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d request words and %0d result words over %0d limit settings",
               words_sent, results_seen, n_limits + 1);
      $display("  %0d sets, %0d checks, %0d checks saw an ended timer",
               n_sets, n_checks, n_ended);
      if (errors == 0) begin
         $display("[timer_bank_with_wrapping_tick_counter_core] OK");
      end else begin
         $display("[timer_bank_with_wrapping_tick_counter_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[timer_bank_with_wrapping_tick_counter_core] ERROR");
      $finish;
   end

endmodule

// ===== timer_bank_with_wrapping_tick_counter_core.f =====
+incdir+sv
sv/tbw_pkg.sv
sv/tbw_if.sv
sv/tbw_ctrl.sv
sv/tbw_datapath.sv
sv/timer_bank_with_wrapping_tick_counter_core.sv
sv/tbw_checker.sv
tb/timer_bank_with_wrapping_tick_counter_core_tb.sv
